FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define PSMR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PSMR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/psmr_pkg.sv
`timescale 1ns / 1ps

package psmr_pkg;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [1:0] {
      KIND_MOVE   = 2'd0,
      KIND_BUTTON = 2'd1,
      KIND_POLL   = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RESOLUTION = 3'd0,
      REG_REPORTING  = 3'd1,
      REG_MIN_LIMIT  = 3'd2,
      REG_MAX_LIMIT  = 3'd3,
      REG_DOWNSCALE  = 3'd4,
      REG_ACCELERATE = 3'd5
   } reg_index_type;

   localparam logic [1:0]         RESOLUTION_RESET = 2'd2;
   localparam logic signed [15:0] MIN_LIMIT_RESET  = -16'sd255;
   localparam logic signed [15:0] MAX_LIMIT_RESET  = 16'sd255;
   localparam logic signed [15:0] Z_MIN            = -16'sd8;
   localparam logic signed [15:0] Z_MAX            = 16'sd7;
   localparam logic signed [15:0] ACCEL_LIMIT      = 16'sd6;

   typedef struct packed {
      logic [1:0]         resolution_index;
      logic               reporting_enable;
      logic signed [15:0] min_limit;
      logic signed [15:0] max_limit;
      logic [3:0]         downscale_shift;
      logic               accelerate_enable;
   } cfg_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] delta_x;
      logic signed [15:0] delta_y;
      logic signed [15:0] delta_z;
      logic [2:0]         button_index;
      logic               button_value;
   } item_type;

   typedef struct packed {
      logic               report_valid;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [3:0]  out_z;
      logic [7:0]         out_buttons;
   } result_type;

   // 2:1 scaling curve for inputs -5..5, indexed by value + 5.
   function automatic logic signed [15:0] accel_curve(input logic [3:0] idx);
      logic signed [15:0] r;
      case (idx)
         4'd0:    r = -16'sd9;
         4'd1:    r = -16'sd6;
         4'd2:    r = -16'sd3;
         4'd3:    r = -16'sd1;
         4'd4:    r = -16'sd1;
         4'd5:    r = 16'sd0;
         4'd6:    r = 16'sd1;
         4'd7:    r = 16'sd1;
         4'd8:    r = 16'sd3;
         4'd9:    r = 16'sd6;
         4'd10:   r = 16'sd9;
         default: r = 16'sd0;
      endcase
      return r;
   endfunction

endpackage

FILE: hdl/ps2_mouse_motion_reporter_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// PS/2 mouse movement reporter.
// Items arrive on the req_ stream: req_tuser carries the kind (move, button,
// poll) and req_tdata the deltas and the button change. Move and button items
// update the accumulators and button map and give no result. A poll gives one
// transfer on the rsp_ stream when reporting is enabled and an update is
// pending; otherwise it is consumed silently.
// Registers are written through the csr_ channel, which is always ready and
// should only be used while the block is idle.
// An accepted item sits in the input register; its report is then loaded
// into the output register, which drives rsp_tvalid, once that register is
// free or its report is being taken.
// Throughput: one item per cycle while no poll waits on a stalled output
// register, set by the single pass of accumulate, shift, clamp and scaling
// logic between the input and output registers.
// When the receiver stalls, the output register holds the report; the input
// register keeps taking move and button items, and a poll waits there until
// the output register frees up.
// Reset clears the accumulators, buttons, pending flag and both registers and
// loads the register defaults; an item or report held in them is dropped.

module ps2_mouse_motion_reporter_top (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: delta_x[15:0], delta_y[31:16], delta_z[47:32],
   //        button_index[50:48], button_value[51], zero[55:52]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [psmr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: kind[1:0]
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: out_x[15:0], out_y[31:16], out_z[35:32], out_buttons[43:36],
   //        zero[47:44]
   output logic [psmr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // tuser: report_valid[0]
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [psmr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psmr_pkg::CSR_DATA_W-1:0]  csr_data
);
   import psmr_pkg::*;

   cfg_type    cfg;
   logic       accum_clear;

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff, item_in;
   logic       out_valid_ff, out_valid_in;
   result_type result_ff;
   result_type result;
   logic       produce;
   logic       advance;
   logic       load_out;
   logic       rsp_stalled;
   logic       regs_empty;

   psmr_cfg u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cfg         (cfg),
      .accum_clear (accum_clear)
   );

   psmr_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .accum_clear (accum_clear),
      .item_valid  (in_valid_ff),
      .item        (item_ff),
      .advance     (advance),
      .produce     (produce),
      .result      (result)
   );

   always_comb begin
      item_in.kind         = kind_type'(req_tuser);
      item_in.delta_x      = $signed(req_tdata[15:0]);
      item_in.delta_y      = $signed(req_tdata[31:16]);
      item_in.delta_z      = $signed(req_tdata[47:32]);
      item_in.button_index = req_tdata[50:48];
      item_in.button_value = req_tdata[51];
   end

   // An item leaves the input register unless it has a report to hand over
   // and the output register is still full.
   assign advance    = in_valid_ff && (!produce || !out_valid_ff || rsp_tready);
   assign load_out   = advance && produce;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
      if (load_out) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = result_ff.report_valid;
   assign rsp_tdata  = {4'd0, result_ff.out_buttons, result_ff.out_z,
                        result_ff.out_y, result_ff.out_x};

   assign rsp_stalled = out_valid_ff && !rsp_tready;
   assign regs_empty  = !out_valid_ff && !in_valid_ff;

   `PSMR_ASSERT(a_no_overwrite, clock, reset, !(load_out && rsp_stalled), "report overwritten")
   `PSMR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> regs_empty, "not empty after reset")

endmodule

FILE: hdl/psmr_cfg.sv
`timescale 1ns / 1ps

module psmr_cfg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [psmr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psmr_pkg::CSR_DATA_W-1:0]  csr_data,
   output psmr_pkg::cfg_type                cfg,
   output logic                             accum_clear
);
   import psmr_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   always_comb begin
      cfg_in      = cfg_ff;
      accum_clear = 1'b0;
      if (wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_RESOLUTION: begin
               cfg_in.resolution_index = csr_data[1:0];
               accum_clear             = 1'b1;
            end
            REG_REPORTING: begin
               cfg_in.reporting_enable = csr_data[0];
               accum_clear             = 1'b1;
            end
            REG_MIN_LIMIT:  cfg_in.min_limit         = $signed(csr_data);
            REG_MAX_LIMIT:  cfg_in.max_limit         = $signed(csr_data);
            REG_DOWNSCALE:  cfg_in.downscale_shift   = csr_data[3:0];
            REG_ACCELERATE: cfg_in.accelerate_enable = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.resolution_index  <= RESOLUTION_RESET;
         cfg_ff.reporting_enable  <= 1'b0;
         cfg_ff.min_limit         <= MIN_LIMIT_RESET;
         cfg_ff.max_limit         <= MAX_LIMIT_RESET;
         cfg_ff.downscale_shift   <= 4'd0;
         cfg_ff.accelerate_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/psmr_engine.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psmr_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  psmr_pkg::cfg_type    cfg,
   input  logic                 accum_clear,
   input  logic                 item_valid,
   input  psmr_pkg::item_type   item,
   input  logic                 advance,
   output logic                 produce,
   output psmr_pkg::result_type result
);
   import psmr_pkg::*;

   typedef struct packed {
      logic signed [15:0] value;
      logic signed [15:0] acc_next;
      logic               clamped;
   } axis_type;

   logic signed [15:0] accum_x_ff, accum_x_in;
   logic signed [15:0] accum_y_ff, accum_y_in;
   logic signed [15:0] accum_z_ff, accum_z_in;
   logic [7:0]         buttons_ff, buttons_in;
   logic               pending_ff, pending_in;

   logic [1:0]         move_shift;
   logic signed [15:0] move_x, move_y;
   axis_type           take_x, take_y, take_z;

   // Shift the accumulator down, clamp, and keep the shifted-out remainder and whatever the clamp cut off.
   function automatic axis_type take_axis(input logic signed [15:0] acc,
                                          input logic signed [15:0] lo,
                                          input logic signed [15:0] hi,
                                          input logic [3:0] sh);
      axis_type           r;
      logic signed [15:0] v;
      v         = acc >>> sh;
      r.clamped = 1'b0;
      if (v < lo) begin
         v         = lo;
         r.clamped = 1'b1;
      end else if (v > hi) begin
         v         = hi;
         r.clamped = 1'b1;
      end
      r.value    = v;
      r.acc_next = acc - (v << sh);
      return r;
   endfunction

   // Division by 2^s rounding toward zero: bias negative values first.
   function automatic logic signed [15:0] div_trunc(input logic signed [15:0] d,
                                                     input logic [1:0] s);
      logic [15:0] bias;
      bias = d[15] ? ((16'd1 << s) - 16'd1) : 16'd0;
      return $signed(d + bias) >>> s;
   endfunction

   function automatic logic signed [15:0] accelerate(input logic signed [15:0] v);
      logic signed [15:0] r;
      if (v > -ACCEL_LIMIT && v < ACCEL_LIMIT) begin
         r = accel_curve(v[3:0] + 4'd5);
      end else begin
         r = v << 1;
      end
      return r;
   endfunction

   assign move_shift = 2'd3 - cfg.resolution_index;
   assign move_x     = div_trunc(item.delta_x, move_shift);
   assign move_y     = div_trunc(item.delta_y, move_shift);

   assign take_x = take_axis(accum_x_ff, cfg.min_limit, cfg.max_limit, cfg.downscale_shift);
   assign take_y = take_axis(accum_y_ff, cfg.min_limit, cfg.max_limit, cfg.downscale_shift);
   assign take_z = take_axis(accum_z_ff, Z_MIN, Z_MAX, 4'd0);

   assign produce = item_valid && (item.kind == KIND_POLL) && cfg.reporting_enable
                    && pending_ff;

   always_comb begin
      result.report_valid = 1'b1;
      result.out_x        = cfg.accelerate_enable ? accelerate(take_x.value) : take_x.value;
      result.out_y        = cfg.accelerate_enable ? accelerate(take_y.value) : take_y.value;
      result.out_z        = take_z.value[3:0];
      result.out_buttons  = buttons_ff;
   end

   always_comb begin
      accum_x_in = accum_x_ff;
      accum_y_in = accum_y_ff;
      accum_z_in = accum_z_ff;
      buttons_in = buttons_ff;
      pending_in = pending_ff;
      if (advance) begin
         case (item.kind)
            KIND_MOVE: begin
               accum_x_in = accum_x_ff + move_x;
               accum_y_in = accum_y_ff + move_y;
               accum_z_in = accum_z_ff + item.delta_z;
               pending_in = 1'b1;
            end
            KIND_BUTTON: begin
               buttons_in[item.button_index] = item.button_value;
               pending_in = 1'b1;
            end
            KIND_POLL: begin
               if (produce) begin
                  accum_x_in = take_x.acc_next;
                  accum_y_in = take_y.acc_next;
                  accum_z_in = take_z.acc_next;
                  pending_in = take_x.clamped || take_y.clamped || take_z.clamped;
               end
            end
            default: ;
         endcase
      end
      if (accum_clear) begin
         accum_x_in = '0;
         accum_y_in = '0;
         accum_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_x_ff <= '0;
         accum_y_ff <= '0;
         accum_z_ff <= '0;
         buttons_ff <= '0;
         pending_ff <= 1'b0;
      end else begin
         accum_x_ff <= accum_x_in;
         accum_y_ff <= accum_y_in;
         accum_z_ff <= accum_z_in;
         buttons_ff <= buttons_in;
         pending_ff <= pending_in;
      end
   end

   `PSMR_ASSERT(a_move_sets_pending, clock, reset, (advance && item.kind == KIND_MOVE) |=> pending_ff, "move did not set the pending flag")
   `PSMR_ASSERT(a_report_needs_enable, clock, reset, produce |-> (cfg.reporting_enable && pending_ff), "report without enable or pending update")

endmodule

FILE: verif/tb_ps2_mouse_motion_reporter_top.sv
`timescale 1ns / 1ps

module tb_ps2_mouse_motion_reporter_top;
   import psmr_pkg::*;

   localparam int QUIET_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 6;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 96;
   localparam int IDLE_PERCENT    = 35;

   // Kind value that has no meaning; the block must drop it.
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   // Register indexes past the end of the register list.
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   localparam int RES_DIVISOR [4]  = '{8, 4, 2, 1};
   localparam int SCALE_CURVE [11] = '{-9, -6, -3, -1, -1, 0, 1, 1, 3, 6, 9};

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   ps2_mouse_motion_reporter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mirror of the block's registers and state.
   cfg_type     mouse_cfg;
   logic [15:0] acc_x;
   logic [15:0] acc_y;
   logic [15:0] acc_z;
   logic [7:0]  buttons_now;
   bit          upd_pending;

   result_type  pending_reports[$];
   result_type  due_report;

   bit sender_gaps_on   = 1'b1;
   bit receiver_stalls_on = 1'b1;
   int fail_count      = 0;
   int items_sent      = 0;
   int reports_checked = 0;
   int config_writes   = 0;
   int quiet_cycles    = 0;

   function automatic void reset_mouse_model();
      mouse_cfg.resolution_index  = RESOLUTION_RESET;
      mouse_cfg.reporting_enable  = 1'b0;
      mouse_cfg.min_limit         = MIN_LIMIT_RESET;
      mouse_cfg.max_limit         = MAX_LIMIT_RESET;
      mouse_cfg.downscale_shift   = '0;
      mouse_cfg.accelerate_enable = 1'b0;
      acc_x       = '0;
      acc_y       = '0;
      acc_z       = '0;
      buttons_now = '0;
      upd_pending = 1'b0;
   endfunction

   function automatic void write_mouse_cfg(input logic [CSR_INDEX_W-1:0] idx,
                                           input logic [15:0] data);
      case (idx)
         REG_RESOLUTION: begin
            mouse_cfg.resolution_index = data[1:0];
            acc_x = '0;
            acc_y = '0;
            acc_z = '0;
         end
         REG_REPORTING: begin
            mouse_cfg.reporting_enable = data[0];
            acc_x = '0;
            acc_y = '0;
            acc_z = '0;
         end
         REG_MIN_LIMIT:  mouse_cfg.min_limit = data;
         REG_MAX_LIMIT:  mouse_cfg.max_limit = data;
         REG_DOWNSCALE:  mouse_cfg.downscale_shift = data[3:0];
         REG_ACCELERATE: mouse_cfg.accelerate_enable = data[0];
         default: ;
      endcase
   endfunction

   // Takes one axis out of its accumulator; whatever the clamp cuts off stays
   // behind and keeps the update flag set.
   function automatic int draw_axis(inout logic [15:0] acc, input int lo,
                                    input int hi, input int unsigned sh);
      int          v;
      logic [31:0] back;
      v = int'($signed(acc)) >>> sh;
      if (v < lo) begin
         v = lo;
         upd_pending = 1'b1;
      end else if (v > hi) begin
         v = hi;
         upd_pending = 1'b1;
      end
      back = v << sh;
      acc = acc - back[15:0];
      return v;
   endfunction

   function automatic int scale_2to1(input int v);
      logic signed [15:0] w;
      if (v > -6 && v < 6) begin
         return SCALE_CURVE[v + 5];
      end
      w = 16'(v * 2);
      return int'(w);
   endfunction

   function automatic void advance_mouse_model(input item_type it);
      int         dx;
      int         dy;
      int         lo;
      int         hi;
      int         x;
      int         y;
      int         z;
      result_type rep;
      case (it.kind)
         KIND_MOVE: begin
            dx = int'($signed(it.delta_x)) / RES_DIVISOR[mouse_cfg.resolution_index];
            dy = int'($signed(it.delta_y)) / RES_DIVISOR[mouse_cfg.resolution_index];
            acc_x = acc_x + dx[15:0];
            acc_y = acc_y + dy[15:0];
            acc_z = acc_z + it.delta_z;
            upd_pending = 1'b1;
         end
         KIND_BUTTON: begin
            buttons_now[it.button_index] = it.button_value;
            upd_pending = 1'b1;
         end
         KIND_POLL: begin
            if (mouse_cfg.reporting_enable && upd_pending) begin
               upd_pending = 1'b0;
               lo = int'($signed(mouse_cfg.min_limit));
               hi = int'($signed(mouse_cfg.max_limit));
               x = draw_axis(acc_x, lo, hi, 32'(mouse_cfg.downscale_shift));
               y = draw_axis(acc_y, lo, hi, 32'(mouse_cfg.downscale_shift));
               z = draw_axis(acc_z, int'(Z_MIN), int'(Z_MAX), 0);
               if (mouse_cfg.accelerate_enable) begin
                  x = scale_2to1(x);
                  y = scale_2to1(y);
               end
               rep.report_valid = 1'b1;
               rep.out_x        = x[15:0];
               rep.out_y        = y[15:0];
               rep.out_z        = z[3:0];
               rep.out_buttons  = buttons_now;
               pending_reports.push_back(rep);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic item_type make_item(input kind_type k);
      item_type it;
      it.kind         = k;
      it.delta_x      = 16'($urandom);
      it.delta_y      = 16'($urandom);
      it.delta_z      = 16'($urandom);
      it.button_index = 3'($urandom);
      it.button_value = 1'($urandom);
      return it;
   endfunction

   function automatic int random_delta();
      logic signed [15:0] w;
      case ($urandom_range(9))
         0: begin
            w = 16'($urandom);
            return int'(w);
         end
         1, 2:    return int'($urandom_range(0, 4000)) - 2000;
         default: return int'($urandom_range(0, 128)) - 64;
      endcase
   endfunction

   task automatic send_item(input item_type it);
      while (sender_gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {4'b0, it.button_value, it.button_index,
                     it.delta_z, it.delta_y, it.delta_x};
      do @(posedge clock); while (!req_tready);
      advance_mouse_model(it);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_move(input int dx, input int dy, input int dz);
      item_type it;
      it = make_item(KIND_MOVE);
      it.delta_x = dx[15:0];
      it.delta_y = dy[15:0];
      it.delta_z = dz[15:0];
      send_item(it);
   endtask

   task automatic send_button(input int idx, input bit val);
      item_type it;
      it = make_item(KIND_BUTTON);
      it.button_index = idx[2:0];
      it.button_value = val;
      send_item(it);
   endtask

   task automatic send_poll();
      send_item(make_item(KIND_POLL));
   endtask

   // A poll may give no report, so once the last expected report is in, the
   // bench keeps waiting so the pipeline can finish whatever it still holds.
   task automatic wait_block_idle();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int value);
      wait_block_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[15:0];
      do @(posedge clock); while (!csr_ready);
      write_mouse_cfg(idx, value[15:0]);
      config_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reporting_gate();
      send_poll();
      send_move(100, -100, 3);
      send_poll();
      // The earlier move left the update flag set; enabling clears only the
      // accumulators, so this poll reports all zeros.
      write_reg(REG_REPORTING, 1);
      send_poll();
      send_poll();
   endtask

   task automatic test_buttons();
      send_button(7, 1'b1);
      send_button(0, 1'b1);
      send_button(7, 1'b0);
      send_poll();
   endtask

   task automatic test_delta_extremes();
      write_reg(REG_RESOLUTION, 3);
      write_reg(REG_MIN_LIMIT, -32768);
      write_reg(REG_MAX_LIMIT, 32767);
      send_move(32767, -32768, 32767);
      send_poll();
      // Divide by eight truncates toward zero; the wheel clamps low.
      write_reg(REG_RESOLUTION, 0);
      send_move(-15, 15, -32768);
      send_poll();
   endtask

   task automatic test_limits_and_shift();
      // Minimum above maximum: the lower bound is tested first.
      write_reg(REG_MIN_LIMIT, 10);
      write_reg(REG_MAX_LIMIT, -10);
      send_move(40, -40, 0);
      send_poll();
      write_reg(REG_MIN_LIMIT, -32768);
      write_reg(REG_MAX_LIMIT, 32767);
      write_reg(REG_DOWNSCALE, 15);
      write_reg(REG_RESOLUTION, 3);
      send_move(-1, 32767, 0);
      send_poll();
   endtask

   task automatic test_acceleration();
      write_reg(REG_DOWNSCALE, 0);
      write_reg(REG_ACCELERATE, 1);
      write_reg(REG_RESOLUTION, 3);
      send_move(-5, 5, 0);
      send_poll();
      send_move(6, -6, 0);
      send_poll();
      // Doubling past the 16-bit range wraps.
      send_move(20000, -20000, 0);
      send_poll();
   endtask

   task automatic test_ignored_inputs();
      send_item(make_item(kind_type'(KIND_UNUSED)));
      send_poll();
      write_reg(REG_SPARE_LO, $urandom);
      write_reg(REG_SPARE_HI, $urandom);
   endtask

   task automatic test_random_traffic();
      item_type it;
      int       lo;
      int       hi;
      int       sel;
      for (int phase = 0; phase < PHASES; phase++) begin
         case ((phase < 6) ? phase : $urandom_range(0, 5))
            0: begin lo = -32768; hi = 32767; end
            1: begin lo = -255;   hi = 255;   end
            2: begin lo = -4;     hi = 4;     end
            3: begin lo = int'($urandom_range(0, 200)); hi = -lo - 1; end
            4: begin lo = -128;   hi = 127;   end
            default: begin
               lo = -int'($urandom_range(0, 1000));
               hi = int'($urandom_range(0, 1000));
            end
         endcase
         write_reg(REG_RESOLUTION, ($urandom & 16'hFFFC) | $urandom_range(3));
         write_reg(REG_REPORTING,
                   ($urandom & 16'hFFFE) | 32'($urandom_range(9) != 0));
         write_reg(REG_MIN_LIMIT, lo);
         write_reg(REG_MAX_LIMIT, hi);
         if (phase == 0) begin
            write_reg(REG_DOWNSCALE, 15);
         end else if ($urandom_range(3) == 0) begin
            write_reg(REG_DOWNSCALE, $urandom);
         end else begin
            write_reg(REG_DOWNSCALE, ($urandom & 16'hFFF0) | $urandom_range(3));
         end
         write_reg(REG_ACCELERATE, (phase == 2) ? 1 : $urandom);
         // One phase runs with both sides at full speed.
         sender_gaps_on     = (phase != 5);
         receiver_stalls_on = (phase != 5);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
               it = make_item(KIND_MOVE);
               it.delta_x = 16'(random_delta());
               it.delta_y = 16'(random_delta());
               it.delta_z = 16'(random_delta());
            end else if (sel < 60) begin
               it = make_item(KIND_BUTTON);
            end else if (sel < 97) begin
               it = make_item(KIND_POLL);
            end else begin
               it = make_item(kind_type'(KIND_UNUSED));
            end
            send_item(it);
         end
      end
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b1;
   endtask

   always @(negedge clock) begin
      rsp_tready <= !(receiver_stalls_on && $urandom_range(99) < IDLE_PERCENT);
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $error("report transfer with no report expected: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            due_report = pending_reports.pop_front();
            reports_checked++;
            check_field("report_valid", {15'd0, due_report.report_valid},
                        {15'd0, rsp_tuser});
            check_field("out_x", due_report.out_x, rsp_tdata[15:0]);
            check_field("out_y", due_report.out_y, rsp_tdata[31:16]);
            check_field("out_z", {12'd0, due_report.out_z}, {12'd0, rsp_tdata[35:32]});
            check_field("out_buttons", {8'd0, due_report.out_buttons},
                        {8'd0, rsp_tdata[43:36]});
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("tb_ps2_mouse_motion_reporter_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset_mouse_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reporting_gate();
      test_buttons();
      test_delta_extremes();
      test_limits_and_shift();
      test_acceleration();
      test_ignored_inputs();
      test_random_traffic();
      wait_block_idle();
      $display("Sent %0d items (moves, buttons, polls, unused kinds) over %0d phases;",
               items_sent, PHASES);
      $display("checked %0d reports after %0d register writes.",
               reports_checked, config_writes);
      if (fail_count == 0) begin
         $display("tb_ps2_mouse_motion_reporter_top passed");
      end else begin
         $display("tb_ps2_mouse_motion_reporter_top failed");
      end
      $finish;
   end

endmodule
